// ===== rtl/blh_pkg.sv =====
package blh_pkg;

	localparam int MV_W    = 13;
	localparam int VOL_W   = MV_W + 1;
	localparam int DELTA_W = 8;
	localparam int LVL_W   = 7;
	localparam int PCT_W   = 8;
	localparam int SUM_W   = 16;
	localparam int IDX_W   = 8;

	localparam int AVG_SAMPLES_DEF = 10;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_FULL  = 8'd0;
	localparam logic [IDX_W-1:0] REG_FLAT  = 8'd1;
	localparam logic [IDX_W-1:0] REG_EMPTY = 8'd2;
	localparam logic [IDX_W-1:0] REG_FAULT = 8'd3;

	localparam logic [MV_W-1:0]    FULL_RST  = 13'd4155;
	localparam logic [DELTA_W-1:0] FLAT_RST  = 8'd4;
	localparam logic [MV_W-1:0]    EMPTY_RST = 13'd3310;
	localparam logic [MV_W-1:0]    FAULT_RST = 13'd2700;

	localparam logic [LVL_W-1:0] LVL_0   = 7'd0;
	localparam logic [LVL_W-1:0] LVL_25  = 7'd25;
	localparam logic [LVL_W-1:0] LVL_50  = 7'd50;
	localparam logic [LVL_W-1:0] LVL_75  = 7'd75;
	localparam logic [LVL_W-1:0] LVL_100 = 7'd100;

	localparam logic signed [PCT_W-1:0] PCT_INVALID = -8'sd1;

	// band thresholds on the corrected voltage
	localparam logic signed [VOL_W-1:0] TOP_MIN    = 14'sd4000;
	localparam logic signed [VOL_W-1:0] B75_MIN    = 14'sd3850;
	localparam logic signed [VOL_W-1:0] B75_ENTER  = 14'sd3950;
	localparam logic signed [VOL_W-1:0] B50_MIN    = 14'sd3650;
	localparam logic signed [VOL_W-1:0] B50_ENTER  = 14'sd3750;
	localparam logic signed [VOL_W-1:0] B25_ENTER  = 14'sd3400;

	localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;
	localparam logic [MV_W-1:0]  AVG_MAX = 13'h1FFF;

	// charging compensation subtracted from the raw reading
	function automatic logic [DELTA_W-1:0] charge_offset(input logic [MV_W-1:0] mv);
		logic [DELTA_W-1:0] ofs;
		if (mv < 13'd3800)      ofs = 8'd230;
		else if (mv < 13'd3920) ofs = 8'd200;
		else if (mv < 13'd4020) ofs = 8'd170;
		else if (mv < 13'd4070) ofs = 8'd150;
		else if (mv < 13'd4100) ofs = 8'd120;
		else if (mv < 13'd4110) ofs = 8'd80;
		else if (mv < 13'd4300) ofs = 8'd60;
		else                    ofs = 8'd0;
		return ofs;
	endfunction

endpackage

// ===== rtl/battery_level_hysteresis_gauge.sv =====
// an input transfer passes the input stage register, then the m_tdata result register
// throughput: one item per cycle unless m_tready stalls the output, one result per item;
//   the held level and averaging state update between the two registers sets the rate
// reset (arst_n low, asynchronous): registers back to their reset values, held level,
//   sample count, sum and last average cleared, both stages empty
module battery_level_hysteresis_gauge import blh_pkg::*; #(
	parameter int AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // measured_mv[12:0], forced_mv[25:13], zero pad
	input  logic             s_tuser,   // charger_present[0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,   // level_percent[7:0], shutdown_request[8], zero pad
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int CNT_W    = $clog2(AVG_SAMPLES);
	localparam int RECIP_SH = 20;
	localparam logic [RECIP_SH-1:0] RECIP_M =
		RECIP_SH'(((64'd1 << RECIP_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES);
	localparam logic [CNT_W:0]   AVG_N   = (CNT_W+1)'(AVG_SAMPLES);

	// configuration registers
	logic [MV_W-1:0]    full_q, empty_q, fault_q;
	logic [DELTA_W-1:0] flat_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= FULL_RST;
			flat_q  <= FLAT_RST;
			empty_q <= EMPTY_RST;
			fault_q <= FAULT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FULL:  full_q  <= cfg_data[MV_W-1:0];
				REG_FLAT:  flat_q  <= cfg_data[DELTA_W-1:0];
				REG_EMPTY: empty_q <= cfg_data[MV_W-1:0];
				REG_FAULT: fault_q <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic            v_s1;
	logic [MV_W-1:0] meas_s1, forced_s1;
	logic            chg_s1;
	logic            adv;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			meas_s1   <= s_tdata[MV_W-1:0];
			forced_s1 <= s_tdata[2*MV_W-1:MV_W];
			chg_s1    <= s_tuser;
		end
	end

	// gauge state
	logic [LVL_W-1:0] held_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [MV_W-1:0]  last_avg_q;

	logic [LVL_W-1:0] held_d;
	logic [CNT_W-1:0] count_d;
	logic [SUM_W-1:0] sum_d;
	logic [MV_W-1:0]  last_avg_d;

	logic signed [VOL_W-1:0] vol;
	logic [SUM_W:0]          sum_ext;
	logic [SUM_W-1:0]        sum_sat;
	logic [CNT_W:0]          cnt_inc;
	logic [SUM_W+RECIP_SH-1:0] prod;
	logic [SUM_W-1:0]        quo;
	logic [MV_W-1:0]         avg;
	logic signed [MV_W+1:0]  diff;
	logic                    done;
	logic signed [PCT_W-1:0] level;
	logic                    shut;

	always_comb begin
		if (forced_s1 != '0) begin
			vol = $signed({1'b0, forced_s1});
		end else if (chg_s1) begin
			vol = $signed({1'b0, meas_s1}) - $signed({6'b0, charge_offset(meas_s1)});
		end else begin
			vol = $signed({1'b0, meas_s1});
		end

		sum_ext = {1'b0, sum_q} + {4'b0, vol[MV_W-1:0]};
		sum_sat = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
		cnt_inc = {1'b0, count_q} + (CNT_W+1)'(1);

		// divide by the sample count: rounded-up reciprocal, exact for 16-bit sums
		prod = (SUM_W+RECIP_SH)'(sum_sat) * (SUM_W+RECIP_SH)'(RECIP_M);
		quo  = prod[SUM_W+RECIP_SH-1:RECIP_SH];
		avg  = (quo > {3'b0, AVG_MAX}) ? AVG_MAX : quo[MV_W-1:0];

		held_d     = held_q;
		count_d    = count_q;
		sum_d      = sum_q;
		last_avg_d = last_avg_q;
		diff       = '0;
		done       = 1'b0;
		level      = '0;
		shut       = 1'b0;

		if (vol >= TOP_MIN) begin
			if (held_q < LVL_100) begin
				if (chg_s1) begin
					if (cnt_inc == AVG_N) begin
						diff       = $signed({2'b0, avg}) - $signed({2'b0, last_avg_q});
						last_avg_d = avg;
						sum_d      = '0;
						count_d    = '0;
					end else begin
						sum_d   = sum_sat;
						count_d = cnt_inc[CNT_W-1:0];
					end
				end else begin
					count_d    = '0;
					sum_d      = '0;
					last_avg_d = '0;
				end
				done = (vol > $signed({1'b0, full_q})) ||
				       (diff < $signed({7'b0, flat_q}));
			end else begin
				done = 1'b1;
			end
			if (done) begin
				level  = PCT_W'(LVL_100);
				held_d = LVL_100;
			end
		end
		if (!done && vol >= B75_MIN && (held_q >= LVL_75 || vol > B75_ENTER)) begin
			level  = PCT_W'(LVL_75);
			held_d = LVL_75;
			done   = 1'b1;
		end
		if (!done && vol >= B50_MIN && (held_q >= LVL_50 || vol > B50_ENTER)) begin
			level  = PCT_W'(LVL_50);
			held_d = LVL_50;
			done   = 1'b1;
		end
		if (!done) begin
			if (vol >= $signed({1'b0, empty_q})) begin
				if (held_q >= LVL_25 || vol > B25_ENTER) begin
					level  = PCT_W'(LVL_25);
					held_d = LVL_25;
				end
			end else if (!chg_s1) begin
				// empty without a charger: shutdown, or invalid when implausibly low
				if (vol >= $signed({1'b0, fault_q})) shut = 1'b1;
				else level = PCT_INVALID;
			end
		end
	end

	logic fire1;
	assign fire1 = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= LVL_0;
			count_q    <= '0;
			sum_q      <= '0;
			last_avg_q <= '0;
		end else if (fire1) begin
			held_q     <= held_d;
			count_q    <= count_d;
			sum_q      <= sum_d;
			last_avg_q <= last_avg_d;
		end
	end

	// result register
	logic [PCT_W-1:0] level_q;
	logic             shut_q;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			level_q <= level;
			shut_q  <= shut;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, shut_q, level_q};

	// assertions
	a_shut_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[PCT_W] |-> m_tdata[PCT_W-1:0] == '0)
		else $error("shutdown with nonzero level");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} < AVG_N)
		else $error("sample count reached the average length");

	a_held_valid: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == LVL_0 || held_q == LVL_25 || held_q == LVL_50 ||
		held_q == LVL_75 || held_q == LVL_100)
		else $error("held level is not a band level");

	a_invalid_keeps_held: assert property (@(posedge clk) disable iff (!arst_n)
		fire1 && level == PCT_INVALID |=> $stable(held_q))
		else $error("invalid reading changed held level");

	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && m_tvalid && !m_tready |=> v_s1 && m_tvalid && $stable(level_q))
		else $error("item dropped under backpressure");

endmodule

// ===== tb/battery_level_hysteresis_gauge_tb.sv =====
module battery_level_hysteresis_gauge_tb import blh_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MV_LIMIT      = 6000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 119;
	localparam int QUIET_LIMIT   = 2000;
	localparam int MAX_REPORTS   = 10;

	// band edges on the corrected voltage
	localparam logic signed [VOL_W-1:0] V_TOP        = 14'sd4000;
	localparam logic signed [VOL_W-1:0] V_HIGH_KEEP  = 14'sd3850;
	localparam logic signed [VOL_W-1:0] V_HIGH_ENTER = 14'sd3950;
	localparam logic signed [VOL_W-1:0] V_MID_KEEP   = 14'sd3650;
	localparam logic signed [VOL_W-1:0] V_MID_ENTER  = 14'sd3750;
	localparam logic signed [VOL_W-1:0] V_LOW_ENTER  = 14'sd3400;

	typedef enum {PACE_BURST, PACE_LIGHT, PACE_HEAVY} pace_t;

	typedef struct packed {
		logic [MV_W-1:0] measured_mv;
		logic [MV_W-1:0] forced_mv;
		logic            charger_present;
	} reading_t;

	typedef struct packed {
		logic signed [PCT_W-1:0] level_percent;
		logic                    shutdown_request;
	} gauge_out_t;

	typedef struct packed {
		reading_t   rd;
		logic       typed;
		gauge_out_t want;
	} directed_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [31:0]      s_tdata;
	logic             s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [15:0]      m_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [15:0]      cfg_data;

	battery_level_hysteresis_gauge dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of registers and state
	logic [MV_W-1:0]    full_mv_q;
	logic [DELTA_W-1:0] flat_delta_q;
	logic [MV_W-1:0]    empty_mv_q;
	logic [MV_W-1:0]    fault_mv_q;
	logic [LVL_W-1:0]   held_lvl;
	logic [3:0]         avg_count;
	logic [SUM_W-1:0]   avg_sum;
	logic [MV_W-1:0]    prev_avg;

	gauge_out_t level_expect_q [$];

	int    err_count;
	int    readings_sent;
	int    results_seen;
	int    settings_written;
	int    averages_done;
	int    seen_full;
	int    seen_shutdown;
	int    seen_invalid;
	int    tx_left;
	int    rx_left;
	pace_t tx_pace;
	pace_t rx_pace;
	int    charge_run_left;
	int    charge_run_mv;
	int    charge_run_slope;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] charging_offset(input logic [MV_W-1:0] mv);
		if (mv < 13'd3800) return 8'd230;
		if (mv < 13'd3920) return 8'd200;
		if (mv < 13'd4020) return 8'd170;
		if (mv < 13'd4070) return 8'd150;
		if (mv < 13'd4100) return 8'd120;
		if (mv < 13'd4110) return 8'd80;
		if (mv < 13'd4300) return 8'd60;
		return 8'd0;
	endfunction

	function automatic gauge_out_t gauge_predict(input reading_t rd);
		logic signed [VOL_W-1:0] vol;
		logic signed [VOL_W:0]   delta;
		logic [SUM_W:0]          sum_next;
		logic [SUM_W:0]          quot;
		logic [4:0]              cnt_next;
		logic [MV_W-1:0]         avg;
		logic                    settled;
		gauge_out_t              res;
		res = '0;
		settled = 1'b0;
		delta = '0;
		if (rd.forced_mv == '0) begin
			vol = $signed({1'b0, rd.measured_mv});
			if (rd.charger_present)
				vol = vol - $signed({6'b0, charging_offset(rd.measured_mv)});
		end else begin
			vol = $signed({1'b0, rd.forced_mv});
		end

		if (vol >= V_TOP) begin
			if (held_lvl < LVL_100) begin
				if (rd.charger_present) begin
					sum_next = {1'b0, avg_sum} + {4'b0, vol[MV_W-1:0]};
					if (sum_next > {1'b0, SUM_MAX})
						sum_next = {1'b0, SUM_MAX};
					cnt_next = {1'b0, avg_count} + 5'd1;
					if (cnt_next >= AVG_SAMPLES_DEF) begin
						quot = sum_next / cnt_next;
						avg = (quot > {4'b0, AVG_MAX}) ? AVG_MAX : quot[MV_W-1:0];
						delta = $signed({2'b0, avg}) - $signed({2'b0, prev_avg});
						prev_avg = avg;
						avg_sum = '0;
						avg_count = '0;
						averages_done++;
					end else begin
						avg_sum = sum_next[SUM_W-1:0];
						avg_count = cnt_next[3:0];
					end
				end else begin
					avg_sum = '0;
					avg_count = '0;
					prev_avg = '0;
				end
				settled = (vol > $signed({1'b0, full_mv_q})) ||
					(delta < $signed({7'b0, flat_delta_q}));
			end else begin
				settled = 1'b1;
			end
			if (settled) begin
				res.level_percent = $signed({1'b0, LVL_100});
				held_lvl = LVL_100;
			end
		end
		if (!settled && vol >= V_HIGH_KEEP && (held_lvl >= LVL_75 || vol > V_HIGH_ENTER)) begin
			res.level_percent = $signed({1'b0, LVL_75});
			held_lvl = LVL_75;
			settled = 1'b1;
		end
		if (!settled && vol >= V_MID_KEEP && (held_lvl >= LVL_50 || vol > V_MID_ENTER)) begin
			res.level_percent = $signed({1'b0, LVL_50});
			held_lvl = LVL_50;
			settled = 1'b1;
		end
		if (!settled) begin
			if (vol >= $signed({1'b0, empty_mv_q})) begin
				if (held_lvl >= LVL_25 || vol > V_LOW_ENTER) begin
					res.level_percent = $signed({1'b0, LVL_25});
					held_lvl = LVL_25;
				end
			end else if (!rd.charger_present) begin
				if (vol >= $signed({1'b0, fault_mv_q}))
					res.shutdown_request = 1'b1;
				else
					res.level_percent = PCT_INVALID;
			end
		end
		return res;
	endfunction

	function automatic directed_row_t dir_row(input int meas, input int forced, input bit chg,
			input bit typed = 1'b0, input int lvl = 0, input bit shut = 1'b0);
		directed_row_t r;
		r.rd.measured_mv = MV_W'(meas);
		r.rd.forced_mv = MV_W'(forced);
		r.rd.charger_present = chg;
		r.typed = typed;
		r.want.level_percent = PCT_W'(lvl);
		r.want.shutdown_request = shut;
		return r;
	endfunction

	function automatic logic [MV_W-1:0] clamp_mv(input int v, input int lo);
		if (v < lo) return MV_W'(lo);
		if (v > MV_LIMIT) return MV_W'(MV_LIMIT);
		return MV_W'(v);
	endfunction

	function automatic int draw_gap(inout int left, inout pace_t pace);
		int gap;
		if (left == 0) begin
			left = $urandom_range(60, 5);
			pace = pace_t'($urandom_range(2, 0));
		end
		left--;
		case (pace)
			PACE_BURST: gap = 0;
			PACE_LIGHT: gap = ($urandom_range(3, 0) == 0) ? $urandom_range(13, 0) : 0;
			default:    gap = $urandom_range(13, 0);
		endcase
		return gap;
	endfunction

	// mostly charging runs in the top band, with readings near every edge in between
	function automatic reading_t random_reading();
		reading_t rd;
		int       v;
		int       pick;
		int       marks [9];
		int       edges [7];
		rd.measured_mv = MV_W'($urandom_range(MV_LIMIT, 0));
		rd.forced_mv = '0;
		rd.charger_present = 1'($urandom_range(1, 0));
		if (charge_run_left > 0) begin
			v = charge_run_mv + $urandom_range(4, 0) - 2;
			charge_run_mv += charge_run_slope;
			charge_run_left--;
			rd.charger_present = ($urandom_range(19, 0) != 0);
			// raw reading where the charging offset is 60
			if (v + 60 >= 4110 && v + 60 < 4300 && $urandom_range(3, 0) == 0)
				rd.measured_mv = MV_W'(v + 60);
			else
				rd.forced_mv = clamp_mv(v, 1);
			return rd;
		end
		pick = $urandom_range(99, 0);
		if (pick < 25) begin
			marks = '{fault_mv_q, empty_mv_q, 3400, 3650, 3750, 3850, 3950, 4000, full_mv_q};
			v = marks[$urandom_range(8, 0)] + $urandom_range(6, 0) - 3;
			rd.forced_mv = clamp_mv(v, 1);
		end else if (pick < 45) begin
			edges = '{3800, 3920, 4020, 4070, 4100, 4110, 4300};
			v = edges[$urandom_range(6, 0)] + $urandom_range(4, 0) - 2;
			rd.measured_mv = clamp_mv(v, 0);
			rd.charger_present = ($urandom_range(3, 0) != 0);
		end else if (pick < 60) begin
			rd.forced_mv = '0;
		end else if (pick < 72) begin
			rd.forced_mv = MV_W'($urandom_range(MV_LIMIT, 0));
		end else begin
			// knock the held level out of the top band, then charge
			charge_run_left = $urandom_range(30, 10);
			charge_run_mv = $urandom_range(4250, 4000);
			charge_run_slope = $urandom_range(8, 0) - 4;
			rd.forced_mv = MV_W'($urandom_range(3950, 3860));
			rd.charger_present = 1'b1;
		end
		return rd;
	endfunction

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic send_reading(input reading_t rd, input logic typed, input gauge_out_t typed_out);
		int         gap;
		gauge_out_t model_out;
		gap = draw_gap(tx_left, tx_pace);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {6'b0, rd.forced_mv, rd.measured_mv};
		s_tuser <= rd.charger_present;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		model_out = gauge_predict(rd);
		level_expect_q.push_back(typed ? typed_out : model_out);
		readings_sent++;
		@(negedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input int value);
		cfg_index <= idx;
		cfg_data <= 16'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FULL:  full_mv_q = MV_W'(value);
			REG_FLAT:  flat_delta_q = DELTA_W'(value);
			REG_EMPTY: empty_mv_q = MV_W'(value);
			REG_FAULT: fault_mv_q = MV_W'(value);
			default: ;
		endcase
		settings_written++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (level_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// stimulus and register settings
	initial begin
		directed_row_t dir_table [$];
		int            full_set;
		int            flat_set;
		int            empty_set;
		int            fault_set;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_count = 0;
		readings_sent = 0;
		settings_written = 0;
		averages_done = 0;
		tx_left = 0;
		rx_left = 0;
		tx_pace = PACE_BURST;
		rx_pace = PACE_BURST;
		charge_run_left = 0;
		charge_run_mv = 0;
		charge_run_slope = 0;
		full_mv_q = FULL_RST;
		flat_delta_q = FLAT_RST;
		empty_mv_q = EMPTY_RST;
		fault_mv_q = FAULT_RST;
		held_lvl = LVL_0;
		avg_count = '0;
		avg_sum = '0;
		prev_avg = '0;

		dir_table = '{
			dir_row(0, 0, 0, 1, PCT_INVALID, 0),
			dir_row(0, 3400, 0, 1, LVL_0, 0),        // held level zero, no entry at 3400
			dir_row(0, 0, 1, 1, LVL_0, 0),           // corrected voltage goes negative
			dir_row(5000, 3380, 1),
			dir_row(3799, 0, 1),
			dir_row(3800, 0, 1),
			dir_row(3919, 0, 1),
			dir_row(3920, 0, 1),
			dir_row(4019, 0, 1),
			dir_row(4020, 0, 1),
			dir_row(4069, 0, 1),
			dir_row(4070, 0, 1),
			dir_row(4099, 0, 1),
			dir_row(4100, 0, 1),
			dir_row(4109, 0, 1),
			dir_row(4110, 0, 1),
			dir_row(4299, 0, 1),
			dir_row(4300, 0, 1),
			dir_row(6000, 0, 0, 1, LVL_100, 0),
			dir_row(0, 6000, 1, 1, LVL_100, 0),
			dir_row(0, 3000, 0, 1, LVL_0, 1),
			dir_row(0, 3000, 1, 1, LVL_0, 0),
			dir_row(0, 2700, 0, 1, LVL_0, 1),
			dir_row(0, 2699, 0, 1, PCT_INVALID, 0),
			dir_row(6000, 1, 0, 1, PCT_INVALID, 0),
			dir_row(0, 3850, 0)
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_table[i])
			send_reading(dir_table[i].rd, dir_table[i].typed, dir_table[i].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain_results();
				case (phase)
					1: begin
						full_set = MV_LIMIT; flat_set = 0;
						empty_set = EMPTY_RST; fault_set = FAULT_RST;
					end
					2: begin
						full_set = 0; flat_set = 255; empty_set = 0; fault_set = 0;
					end
					3: begin
						full_set = MV_LIMIT; flat_set = 255;
						empty_set = MV_LIMIT; fault_set = MV_LIMIT;
					end
					4: begin
						full_set = 4200; flat_set = $urandom_range(8, 0);
						empty_set = EMPTY_RST; fault_set = FAULT_RST;
					end
					default: begin
						full_set = $urandom_range(4400, 4000);
						flat_set = $urandom_range(12, 0);
						empty_set = $urandom_range(3700, 3000);
						fault_set = $urandom_range(3400, 2000);
					end
				endcase
				write_register(REG_FULL, full_set);
				write_register(REG_FLAT, flat_set);
				write_register(REG_EMPTY, empty_set);
				write_register(REG_FAULT, fault_set);
				cfg_valid <= 1'b0;
			end
			repeat (PHASE_ITEMS)
				send_reading(random_reading(), 1'b0, '0);
		end

		drain_results();
		repeat (8) @(negedge clk);
		$display("%0d readings sent, %0d results checked, %0d register writes, %0d averages closed",
			readings_sent, results_seen, settings_written, averages_done);
		$display("levels seen: %0d full, %0d shutdown, %0d invalid",
			seen_full, seen_shutdown, seen_invalid);
		if (err_count == 0 && level_expect_q.size() == 0) begin
			$display("** battery_level_hysteresis_gauge: PASSED **");
		end else begin
			$display("** battery_level_hysteresis_gauge: FAILED **");
		end
		$finish;
	end

	// result side: stall, accept, compare with the oldest expectation
	initial begin
		gauge_out_t got;
		gauge_out_t want;
		int         gap;
		m_tready = 1'b0;
		results_seen = 0;
		seen_full = 0;
		seen_shutdown = 0;
		seen_invalid = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap(rx_left, rx_pace);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.level_percent = m_tdata[7:0];
			got.shutdown_request = m_tdata[8];
			results_seen++;
			if (got.level_percent == $signed({1'b0, LVL_100})) seen_full++;
			if (got.shutdown_request) seen_shutdown++;
			if (got.level_percent == PCT_INVALID) seen_invalid++;
			if (level_expect_q.size() == 0) begin
				note_error($sformatf("result %0d: level %0d shutdown %0b with nothing expected",
					results_seen, got.level_percent, got.shutdown_request));
			end else begin
				want = level_expect_q.pop_front();
				if (got.level_percent !== want.level_percent ||
						got.shutdown_request !== want.shutdown_request)
					note_error($sformatf(
						"result %0d: level exp %0d got %0d, shutdown exp %0b got %0b",
						results_seen, want.level_percent, got.level_percent,
						want.shutdown_request, got.shutdown_request));
			end
			@(negedge clk);
		end
	end

	// ends the run when no transfer happens for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, level_expect_q.size());
		$display("** battery_level_hysteresis_gauge: FAILED **");
		$finish;
	end

endmodule
